// File: rtl/core/sorted_min_priority_queue_top_defines.svh
// Assertion macros used by the top level of the sorted minimum priority queue.
`ifndef SORTED_MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTH
`define SMPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SMPQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMPQ_ASSERT(lbl, prop, msg)
`define SMPQ_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// File: rtl/core/smpq_pkg.sv
// Types and constants of the sorted minimum priority queue.
package smpq_pkg;

  localparam int DEPTH  = 64;
  localparam int KEY_W  = 16;
  localparam int TAG_W  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ST_W   = 2;
  localparam int ST_DW  = ((KEY_W + TAG_W + 7) / 8) * 8;
  localparam int MT_DW  = ((KEY_W + TAG_W + CNT_W + 7) / 8) * 8;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t fresh;
  } cell_ctl_t;

endpackage

// File: rtl/core/smpq_cell.sv
// One slot of the sorted chain: holds an entry and shifts it up or down.
module smpq_cell (
  input  logic               clk,
  input  smpq_pkg::cell_ctl_t ctl,
  input  logic               occupied,
  input  smpq_pkg::entry_t   left_entry,
  input  logic               left_greater,
  input  smpq_pkg::entry_t   right_entry,
  output smpq_pkg::entry_t   entry,
  output logic               greater
);
  import smpq_pkg::*;

  // An empty slot counts as greater, so a new entry that no held key exceeds lands in the first free slot.
  assign greater = !occupied || (entry.key > ctl.fresh.key);

  always_ff @(posedge clk) begin
    if (ctl.ins && greater) begin
      entry <= left_greater ? left_entry : ctl.fresh;
    end else if (ctl.del) begin
      entry <= right_entry;
    end
  end

endmodule

// File: rtl/core/sorted_min_priority_queue_top.sv
// Top level of the sorted minimum priority queue: cell chain, fill count and result register.
// The queue holds up to DEPTH entries in a chain of cells kept in ascending key order, the
// smallest in cell 0. Every beat is an insert or a delete: all cells compare the new key with
// their own at once and shift in the same clock, so a new beat is accepted every cycle, held
// back only while the registered result is not taken. The result of a beat appears on the
// master side in the cycle after it is accepted. Equal keys leave in arrival order; an insert
// when full returns overflow and a delete when empty underflow, both without changing the
// contents.
module sorted_min_priority_queue_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [smpq_pkg::ST_DW-1:0] s_tdata,  // key, tag
  input  logic                      s_tuser,  // kind
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [smpq_pkg::MT_DW-1:0] m_tdata,  // removed_key, removed_tag, fill_level
  output logic [smpq_pkg::ST_W-1:0]  m_tuser   // status
);
  import smpq_pkg::*;
`include "sorted_min_priority_queue_top_defines.svh"

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             s_acc;
  logic             full;
  logic             empty;
  kind_t            kind;
  cell_ctl_t        ctl;
  entry_t           cells    [DEPTH];
  logic [DEPTH-1:0] greater;
  logic [DEPTH-1:0] occ;

  status_t          out_status;
  logic [KEY_W-1:0] out_key;
  logic [TAG_W-1:0] out_tag;
  logic [CNT_W-1:0] out_fill;

  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;
  assign kind     = kind_t'(s_tuser);
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  assign ctl.ins       = s_acc && (kind == KIND_INSERT) && !full;
  assign ctl.del       = s_acc && (kind == KIND_DELETE) && !empty;
  assign ctl.fresh.key = s_tdata[KEY_W-1:0];
  assign ctl.fresh.tag = s_tdata[KEY_W+TAG_W-1:KEY_W];

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.del) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_g;

    assign occ[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_e = cells[i-1];
      assign left_g = greater[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = cells[i];
    end else begin : g_inner
      assign right_e = cells[i+1];
    end

    smpq_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .occupied     (occ[i]),
      .left_entry   (left_e),
      .left_greater (left_g),
      .right_entry  (right_e),
      .entry        (cells[i]),
      .greater      (greater[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (s_acc) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      out_fill <= count_next;
      out_key  <= '0;
      out_tag  <= '0;
      if (kind == KIND_INSERT) begin
        out_status <= full ? STATUS_OVERFLOW : STATUS_DONE;
      end else if (empty) begin
        out_status <= STATUS_UNDERFLOW;
      end else begin
        out_status <= STATUS_DONE;
        out_key    <= cells[0].key;
        out_tag    <= cells[0].tag;
      end
    end
  end

  assign m_tdata = MT_DW'({out_fill, out_tag, out_key});
  assign m_tuser = out_status;

  `SMPQ_ASSERT(a_count_bound, (count <= CNT_W'(DEPTH)), "fill count exceeds depth")
  `SMPQ_ASSERT(a_overflow, (s_acc && kind == KIND_INSERT && full) |=> (m_tvalid && m_tuser == STATUS_OVERFLOW && count == CNT_W'(DEPTH)), "insert when full not reported")
  `SMPQ_ASSERT(a_delete_count, (ctl.del) |=> (count == $past(count) - CNT_W'(1)), "delete did not lower the count")
  `SMPQ_ASSERT(a_head_sorted, (count >= CNT_W'(2)) |-> (cells[0].key <= cells[1].key), "head of queue out of order")
  `SMPQ_ASSERT_RST(a_reset_clears, rst |=> (!m_tvalid && count == '0), "reset did not clear control state")

endmodule

// File: tb/sv/smpq_checker.sv
// Checker for the sorted minimum priority queue: predicts each result beat and compares it.
module smpq_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [smpq_pkg::ST_DW-1:0] s_tdata,   // key, tag
  input  logic                       s_tuser,   // kind
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [smpq_pkg::MT_DW-1:0] m_tdata,   // removed_key, removed_tag, fill_level
  input  logic [smpq_pkg::ST_W-1:0]  m_tuser,   // status
  output int                         mismatches,
  output int                         pending,
  output int                         removals,
  output int                         overflows,
  output int                         underflows
);
  timeunit 1ns;
  timeprecision 1ps;
  import smpq_pkg::*;

  typedef struct {
    status_t          status;
    logic [KEY_W-1:0] rkey;
    logic [TAG_W-1:0] rtag;
    logic [CNT_W-1:0] fill;
  } outcome_t;

  outcome_t awaited[$];
  entry_t   held[DEPTH];
  int       held_count = 0;
  int       fail_cnt = 0;
  int       rem_cnt  = 0;
  int       ovf_cnt  = 0;
  int       udf_cnt  = 0;

  // Applies one operation to the shadow queue and gives the result it must produce.
  function automatic outcome_t apply_op(kind_t kind, entry_t fresh);
    outcome_t res;
    int       pos;
    res.status = STATUS_DONE;
    res.rkey   = '0;
    res.rtag   = '0;
    if (kind == KIND_INSERT) begin
      if (held_count >= DEPTH) begin
        res.status = STATUS_OVERFLOW;
      end else begin
        // The new entry goes behind every entry whose key is not greater.
        pos = held_count;
        while (pos > 0 && held[pos-1].key > fresh.key) begin
          held[pos] = held[pos-1];
          pos--;
        end
        held[pos] = fresh;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        res.status = STATUS_UNDERFLOW;
      end else begin
        res.rkey = held[0].key;
        res.rtag = held[0].tag;
        for (pos = 1; pos < held_count; pos++) held[pos-1] = held[pos];
        held_count--;
      end
    end
    res.fill = CNT_W'(held_count);
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t due;
    entry_t   fresh;
    if (rst) begin
      awaited.delete();
      held_count = 0;
    end else begin
      // The result beat always belongs to an earlier input beat, so it is taken first.
      if (m_tvalid && m_tready) begin
        if (awaited.size() == 0) begin
          $error("result beat with no operation outstanding: status %0d data %h",
                 m_tuser, m_tdata);
          fail_cnt++;
        end else begin
          due = awaited.pop_front();
          if (m_tuser !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, m_tuser);
            fail_cnt++;
          end
          if (m_tdata[KEY_W-1:0] !== due.rkey) begin
            $error("removed_key: expected %h, got %h", due.rkey, m_tdata[KEY_W-1:0]);
            fail_cnt++;
          end
          if (m_tdata[KEY_W +: TAG_W] !== due.rtag) begin
            $error("removed_tag: expected %h, got %h", due.rtag, m_tdata[KEY_W +: TAG_W]);
            fail_cnt++;
          end
          if (m_tdata[KEY_W+TAG_W +: CNT_W] !== due.fill) begin
            $error("fill_level: expected %0d, got %0d", due.fill,
                   m_tdata[KEY_W+TAG_W +: CNT_W]);
            fail_cnt++;
          end
          case (due.status)
            STATUS_OVERFLOW:  ovf_cnt++;
            STATUS_UNDERFLOW: udf_cnt++;
            default: ;
          endcase
        end
      end
      if (s_tvalid && s_tready) begin
        fresh.key = s_tdata[KEY_W-1:0];
        fresh.tag = s_tdata[KEY_W +: TAG_W];
        due = apply_op(kind_t'(s_tuser), fresh);
        if (s_tuser == KIND_DELETE && due.status == STATUS_DONE) rem_cnt++;
        awaited.push_back(due);
      end
    end
    mismatches <= fail_cnt;
    pending    <= awaited.size();
    removals   <= rem_cnt;
    overflows  <= ovf_cnt;
    underflows <= udf_cnt;
  end

endmodule

// File: tb/sv/sorted_min_priority_queue_top_tb.sv
// Testbench top for the sorted minimum priority queue: stimulus, handshake idling and verdict.
module sorted_min_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smpq_pkg::*;

  localparam int ITEM_TARGET = 550;
  localparam int CALM_FROM   = 490;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {
    RUN_FILL,
    RUN_DRAIN,
    RUN_MIXED
  } run_mode_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [ST_DW-1:0]  s_tdata  = '0;
  logic              s_tuser  = KIND_INSERT;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [MT_DW-1:0]  m_tdata;
  logic [ST_W-1:0]   m_tuser;

  int mismatches;
  int pending;
  int removals;
  int overflows;
  int underflows;
  int items_sent  = 0;
  int cycles      = 0;
  bit src_stalls  = 1'b0;
  bit sink_stalls = 1'b0;

  sorted_min_priority_queue_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  smpq_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (mismatches),
    .pending    (pending),
    .removals   (removals),
    .overflows  (overflows),
    .underflows (underflows)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: holds tready low for bursts of random length while stalls are enabled.
  always begin
    @(posedge clk);
    if (rst || !sink_stalls || $urandom_range(0, 5) != 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 6) - 1) @(posedge clk);
    end
  end

  // Presents one beat and waits until it is taken, then perhaps leaves a gap.
  task automatic send_beat(input kind_t kind, input logic [KEY_W-1:0] key,
                           input logic [TAG_W-1:0] tag);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {tag, key};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (src_stalls && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Mostly a narrow range so that equal keys are common, with the extremes now and then.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return KEY_W'($urandom_range(0, 15));
      6, 7:             return KEY_W'($urandom);
      8:                return '0;
      default:          return '1;
    endcase
  endfunction

  initial begin
    run_mode_t mode;
    int        run_len;
    int        del_pct;
    int        round;
    round = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    src_stalls  = 1'b1;
    sink_stalls = 1'b1;

    // Directed part: empty delete, extreme keys and tags, equal keys, drain past empty.
    send_beat(KIND_DELETE, 16'hFFFF, 16'hFFFF);
    send_beat(KIND_INSERT, 16'hFFFF, 16'h0001);
    send_beat(KIND_INSERT, 16'h0000, 16'hFFFF);
    send_beat(KIND_INSERT, 16'h8000, 16'hAAAA);
    send_beat(KIND_INSERT, 16'h8000, 16'h5555);
    send_beat(KIND_INSERT, 16'h0000, 16'h1234);
    send_beat(KIND_INSERT, 16'hFFFF, 16'h0002);
    send_beat(KIND_INSERT, 16'h7FFF, 16'h0000);
    repeat (8) send_beat(KIND_DELETE, KEY_W'($urandom), TAG_W'($urandom));
    send_beat(KIND_INSERT, 16'h5A5A, 16'hA5A5);
    send_beat(KIND_INSERT, 16'h5A5A, 16'h0F0F);
    send_beat(KIND_DELETE, 16'h0000, 16'h0000);
    send_beat(KIND_DELETE, 16'hFFFF, 16'hFFFF);
    send_beat(KIND_DELETE, 16'h1234, 16'h5678);

    // Random runs: the first fills past full, the second drains past empty.
    while (items_sent < ITEM_TARGET) begin
      if (round == 0) mode = RUN_FILL;
      else if (round == 1) mode = RUN_DRAIN;
      else mode = run_mode_t'($urandom_range(0, 2));
      case (mode)
        RUN_FILL:  del_pct = 5;
        RUN_DRAIN: del_pct = 95;
        default:   del_pct = 50;
      endcase
      run_len = (round < 2) ? 90 : $urandom_range(40, 90);
      src_stalls  = $urandom_range(0, 2) != 0;
      sink_stalls = $urandom_range(0, 2) != 0;
      repeat (run_len) begin
        if (items_sent >= CALM_FROM) begin
          src_stalls  = 1'b0;
          sink_stalls = 1'b0;
        end
        if (items_sent < ITEM_TARGET) begin
          if ($urandom_range(1, 100) <= del_pct)
            send_beat(KIND_DELETE, KEY_W'($urandom), TAG_W'($urandom));
          else
            send_beat(KIND_INSERT, pick_key(), TAG_W'($urandom));
        end
      end
      round++;
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d operations over %0d runs: inserts, deletes, equal and extreme keys",
             items_sent, round);
    $display("%0d entries removed, %0d overflows and %0d underflows checked",
             removals, overflows, underflows);
    if (mismatches == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sorted_min_priority_queue_top.f
+incdir+rtl/core
rtl/core/smpq_pkg.sv
rtl/core/smpq_cell.sv
rtl/core/sorted_min_priority_queue_top.sv
tb/sv/smpq_checker.sv
tb/sv/sorted_min_priority_queue_top_tb.sv
